@@ design/pni_pkg.sv @@
// ----------------------------------------------------------------------------
// pni_pkg
// shared types and register indexes of the polynomial newton inverter
// ----------------------------------------------------------------------------
package pni_pkg;

	localparam int NUM_COEFF_REGS = 5;

	typedef enum logic [2:0] {
		REG_COUNT   = 3'd0,
		REG_COEFF0  = 3'd1,
		REG_COEFF1  = 3'd2,
		REG_COEFF2  = 3'd3,
		REG_COEFF3  = 3'd4,
		REG_COEFF4  = 3'd5,
		REG_TOL     = 3'd6,
		REG_LIMIT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] corrected_sample;
		logic [7:0]  iterations_used;
		logic        converged;
		logic        derivative_zero;
	} result_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctrl_t;

endpackage

@@ design/pni_if.sv @@
// ----------------------------------------------------------------------------
// pni_in_if / pni_out_if
// valid/ready channels carrying sample and result beats
// ----------------------------------------------------------------------------
interface pni_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] distorted_sample;
	modport source (output valid, output distorted_sample, input ready);
	modport sink   (input valid, input distorted_sample, output ready);
endinterface

interface pni_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] corrected_sample;
	logic [7:0]         iterations_used;
	logic               converged;
	logic               derivative_zero;
	modport source (output valid, output corrected_sample, output iterations_used,
		output converged, output derivative_zero, input ready);
	modport sink   (input valid, input corrected_sample, input iterations_used,
		input converged, input derivative_zero, output ready);
endinterface

@@ design/pni_div.sv @@
// ----------------------------------------------------------------------------
// pni_div
// radix-2 restoring divider, signed quotient truncated toward zero
// ----------------------------------------------------------------------------
module pni_div #(
	parameter int NW = 56,
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 done,
	output logic signed [NW:0]   quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] nq_q;
	logic [DW:0]   rem_q;
	logic [DW:0]   dm_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, neg_q;
	logic [DW+1:0] trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], nq_q[NW-1]};
	assign trial   = {1'b0, shifted} - {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				nq_q   <= num[NW-1] ? NW'(-num) : NW'(num);
				dm_q   <= den[DW-1] ? (DW+1)'(-$signed({den[DW-1], den}))
					: {1'b0, den};
				neg_q  <= num[NW-1] ^ den[DW-1];
				rem_q  <= '0;
			end else if (busy_q) begin
				if (!trial[DW+1]) begin
					rem_q <= trial[DW:0];
					nq_q  <= {nq_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					nq_q  <= {nq_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});
endmodule

@@ design/polynomial_newton_inverter.sv @@
// ----------------------------------------------------------------------------
// polynomial_newton_inverter
// newton inversion of y = z + sum c_k z^(k+2), q8.24 fixed point
// ----------------------------------------------------------------------------
// channels: smp (sink) takes one distorted sample per beat, res (source)
// returns one beat with the corrected sample, iteration count and flags.
// configuration through cfg_we / cfg_index / cfg_data while idle.
// one iteration: a setup state, then per coefficient the shared 32x32 multiplier
// forms the power, coefficient times power and coefficient times previous
// power, then the bit-serial divider runs (start, 56 steps, done) and an
// update state follows.
// an iteration that stops on a zero derivative does not wait for the divider.
// one sample at a time: smp.ready is low from acceptance until the result
// beat has been taken, and returns in the cycle after that beat.
// if res.ready is low the result holds in its register.
// reset clears the registers to count 0, coefficients 0, tolerance 17,
// limit 32, and empties the block.
// ----------------------------------------------------------------------------
module polynomial_newton_inverter #(
	parameter int MAX_COEFFS = 5,
	parameter int FRAC_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	pni_in_if.sink      smp,
	pni_out_if.source   res
);
	import pni_pkg::*;

	localparam int NLIM = (MAX_COEFFS < NUM_COEFF_REGS) ? MAX_COEFFS : NUM_COEFF_REGS;
	localparam int NUMW = 32 + FRAC_BITS;
	localparam int AW   = 70 - FRAC_BITS;

	typedef enum logic [2:0] {S_IDLE, S_INIT, S_POW, S_FMUL, S_DMUL, S_DIV, S_UPD,
		S_OUT} state_t;

	state_t             state_q;
	logic [2:0]         count_q;
	logic signed [31:0] coef_q [NUM_COEFF_REGS];
	logic [30:0]        tol_q;
	logic [7:0]         limit_q;
	logic signed [31:0] y_q, z_q, p_q, pn_q;
	logic signed [AW-1:0] f_q, d_q;
	logic [2:0]         k_q, n_q;
	logic [7:0]         used_q;
	logic               start_q;
	result_t            res_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [63:0] rnd;
	logic signed [31:0] sat_rnd, fs, ds, znew;
	logic signed [NUMW:0] q;
	logic signed [NUMW+1:0] zdiff;
	logic signed [33:0] dz;
	logic [33:0]        adz;
	logic               div_done;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	always_comb begin
		unique case (state_q)
			S_POW:   begin ma = p_q; mb = z_q; end
			S_FMUL:  begin ma = coef_q[k_q]; mb = pn_q; end
			default: begin ma = coef_q[k_q]; mb = p_q; end
		endcase
	end

	assign prod    = ma * mb;
	assign rnd     = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign sat_rnd = sat(rnd);
	assign fs      = sat(64'(f_q));
	assign ds      = sat(64'(d_q));
	assign zdiff   = (NUMW+2)'(z_q) - (NUMW+2)'(q);
	assign znew    = sat(64'(zdiff));
	assign dz      = 34'(znew) - 34'(z_q);
	assign adz     = dz[33] ? 34'(-dz) : 34'(dz);

	pni_div #(.NW(NUMW), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.num(NUMW'(fs) <<< FRAC_BITS), .den(ds), .done(div_done), .quo(q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < NUM_COEFF_REGS; i++) coef_q[i] <= '0;
			tol_q   <= 31'd17;
			limit_q <= 8'd32;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COUNT:  count_q   <= cfg_data[2:0];
				REG_COEFF0: coef_q[0] <= cfg_data;
				REG_COEFF1: coef_q[1] <= cfg_data;
				REG_COEFF2: coef_q[2] <= cfg_data;
				REG_COEFF3: coef_q[3] <= cfg_data;
				REG_COEFF4: coef_q[4] <= cfg_data;
				REG_TOL:    tol_q     <= cfg_data[30:0];
				REG_LIMIT:  limit_q   <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (smp.valid) begin
					y_q     <= smp.distorted_sample;
					z_q     <= '0;
					used_q  <= '0;
					n_q     <= (count_q > 3'(NLIM)) ? 3'(NLIM) : count_q;
					state_q <= S_INIT;
				end
				S_INIT: begin
					f_q    <= AW'(y_q) - AW'(z_q);
					d_q    <= -(AW'(1) <<< FRAC_BITS);
					p_q    <= z_q;
					k_q    <= '0;
					used_q <= used_q + 1'b1;
					if (n_q == 3'd0) begin
						state_q <= S_DIV;
						start_q <= 1'b1;
					end else state_q <= S_POW;
				end
				S_POW: begin
					pn_q    <= sat_rnd;
					state_q <= S_FMUL;
				end
				S_FMUL: begin
					f_q     <= f_q - AW'(rnd);
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					d_q <= d_q - AW'(rnd) * AW'({1'b0, k_q} + 4'd2);
					p_q <= pn_q;
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == n_q) begin
						state_q <= S_DIV;
						start_q <= 1'b1;
					end else state_q <= S_POW;
				end
				S_DIV: begin
					if (ds == 0) begin
						res_q   <= '{z_q, used_q, 1'b0, 1'b1};
						state_q <= S_OUT;
					end else if (div_done && !start_q) state_q <= S_UPD;
				end
				S_UPD: begin
					z_q <= znew;
					if (adz <= 34'(tol_q)) begin
						res_q   <= '{znew, used_q, 1'b1, 1'b0};
						state_q <= S_OUT;
					end else if (used_q >= ((limit_q == 0) ? 8'd1 : limit_q)) begin
						res_q   <= '{znew, used_q, 1'b0, 1'b0};
						state_q <= S_OUT;
					end else state_q <= S_INIT;
				end
				S_OUT: if (res.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign smp.ready            = (state_q == S_IDLE);
	assign res.valid            = (state_q == S_OUT);
	assign res.corrected_sample = res_q.corrected_sample;
	assign res.iterations_used  = res_q.iterations_used;
	assign res.converged        = res_q.converged;
	assign res.derivative_zero  = res_q.derivative_zero;

`ifndef ASSERT_OFF
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.converged && res.derivative_zero))
		else $error("both flags set");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.iterations_used != 8'd0)
		else $error("zero iterations reported");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(smp.ready && res.valid))
		else $error("ready while result pending");
`endif
endmodule
